/* rtl/mwtf_pkg.sv */
package mwtf_pkg;

	// operation codes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// access width codes that need special handling
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	// finisher status words and the kind reported for each
	localparam logic [15:0] FIN_FAIL  = 16'h3333;
	localparam logic [15:0] FIN_PASS  = 16'h5555;
	localparam logic [15:0] FIN_RESET = 16'h7777;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_PASS  = 2'd1;
	localparam logic [1:0] KIND_FAIL  = 2'd2;
	localparam logic [1:0] KIND_RESET = 2'd3;

	// configuration register indexes
	localparam int         CFG_IDX_W       = 2;
	localparam logic [1:0] CFG_WINDOW_BASE = 2'd0;
	localparam logic [1:0] CFG_FINISHER    = 2'd1;

	localparam logic [63:0] FIN_ADDR_RESET = 64'h0000_0000_1000_9000;

	// byte lanes, one RAM bank per lane
	localparam int LANES = 8;

	typedef struct packed {
		logic load_in;
		logic calc_off;
		logic calc_lane;
		logic mem_access;
		logic sweep;
		logic finish;
	} mwtf_cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [1:0] size_code;
		logic       sweep_last;
		logic       out_free;
	} mwtf_stat_t;

endpackage

/* rtl/mwtf_ram.sv */
module mwtf_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 512
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/mwtf_ctrl.sv */
module mwtf_ctrl import mwtf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  mwtf_stat_t stat,
	output mwtf_cmd_t  cmd
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_ADDR   = 3'd2;
	localparam logic [2:0] ST_LANE   = 3'd3;
	localparam logic [2:0] ST_ACCESS = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;
	localparam logic [2:0] ST_CLEAR  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = ST_ADDR;
				end
			end
			ST_ADDR: begin
				cmd.calc_off = 1'b1;
				case (stat.opcode)
					OP_READ:  state_n = ST_LANE;
					OP_WRITE: state_n = (stat.size_code == SZ_HALF) ? ST_DONE : ST_LANE;
					OP_CLEAR: state_n = ST_CLEAR;
					default:  state_n = ST_DONE;
				endcase
			end
			ST_LANE: begin
				cmd.calc_lane = 1'b1;
				state_n       = ST_ACCESS;
			end
			ST_ACCESS: begin
				cmd.mem_access = 1'b1;
				state_n        = ST_DONE;
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

/* rtl/mwtf_dp.sv */
module mwtf_dp import mwtf_pkg::*; #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic [1:0]           opcode,
	input  logic [1:0]           size_code,
	input  logic [63:0]          address,
	input  logic [63:0]          write_data,
	input  mwtf_cmd_t            cmd,
	output mwtf_stat_t           stat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          read_data,
	output logic                 read_valid,
	output logic                 unsupported,
	output logic                 terminated,
	output logic [15:0]          exit_status,
	output logic [1:0]           finish_kind
);

	localparam int              ROWS     = (MEM_BYTES + LANES - 1) / LANES;
	localparam int              ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [63:0]     MEM_SIZE = 64'(MEM_BYTES);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	// configuration
	logic [63:0] window_base_q;
	logic [63:0] fin_addr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= '0;
			fin_addr_q    <= FIN_ADDR_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_WINDOW_BASE) begin
				window_base_q <= cfg_data;
			end
			if (cfg_index == CFG_FINISHER) begin
				fin_addr_q <= cfg_data;
			end
		end
	end

	// captured item
	logic [1:0]  op_q;
	logic [1:0]  size_q;
	logic [63:0] addr_q;
	logic [63:0] data_q;
	logic [63:0] off_q;
	logic        fin_hit_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= opcode;
			size_q <= size_code;
			addr_q <= address;
			data_q <= write_data;
		end
		if (cmd.calc_off) begin
			off_q     <= addr_q - window_base_q;
			fin_hit_q <= (addr_q == fin_addr_q);
		end
	end

	logic is_rd;
	logic is_wr;
	assign is_rd = (op_q == OP_READ);
	assign is_wr = (op_q == OP_WRITE) && (size_q != SZ_HALF);

	// per-lane window check and row
	logic [63:0]      lane_off [LANES];
	logic [LANES-1:0] lane_act;
	logic [3:0]       nbytes;
	logic [ROW_W-1:0] lane_row_q [LANES];
	logic [LANES-1:0] lane_ok_q;
	logic [LANES-1:0] lane_act_q;

	assign nbytes = 4'd1 << size_q;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_off[i] = off_q + 64'(i);
			lane_act[i] = (4'(i) < nbytes);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_lane) begin
			for (int i = 0; i < LANES; i++) begin
				lane_row_q[i] <= lane_off[i][ROW_W+2:3];
				lane_ok_q[i]  <= lane_act[i] && (lane_off[i] < MEM_SIZE);
				lane_act_q[i] <= lane_act[i];
			end
		end
	end

	// sweep counter for valid-mark clearing
	logic [ROW_W-1:0] sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= (sweep_q == LAST_ROW) ? '0 : sweep_q + 1'b1;
		end
	end

	// byte banks: {valid mark, data byte}
	logic [8:0] bank_rd [LANES];

	for (genvar b = 0; b < LANES; b++) begin : g_bank
		logic [2:0]       lane;
		logic             we;
		logic             re;
		logic [ROW_W-1:0] waddr;
		logic [8:0]       wdata;

		assign lane = 3'(b) - off_q[2:0];

		always_comb begin
			if (cmd.sweep) begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = '0;
			end else begin
				we    = cmd.mem_access && is_wr && lane_ok_q[lane];
				waddr = lane_row_q[lane];
				wdata = {1'b1, data_q[{lane, 3'b000} +: 8]};
			end
		end

		assign re = cmd.mem_access && is_rd && lane_ok_q[lane];

		mwtf_ram #(
			.WIDTH(9),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata(wdata),
			.re   (re),
			.raddr(lane_row_q[lane]),
			.rdata(bank_rd[b])
		);
	end

	// read assembly
	logic [63:0]      rd_bytes;
	logic [LANES-1:0] lane_good;
	logic             rd_ok;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_good[i]       = !lane_act_q[i] ||
			                     (lane_ok_q[i] && bank_rd[3'(off_q[2:0] + 3'(i))][8]);
			rd_bytes[8*i +: 8] = lane_act_q[i] ? bank_rd[3'(off_q[2:0] + 3'(i))][7:0] : 8'h00;
		end
		rd_ok = is_rd && (&lane_good);
	end

	// finisher state
	logic        term_q;
	logic [15:0] exit_q;
	logic [1:0]  kind_q;
	logic        term_n;
	logic [15:0] exit_n;
	logic [1:0]  kind_n;

	always_comb begin
		term_n = term_q;
		exit_n = exit_q;
		kind_n = kind_q;
		if (op_q == OP_CLEAR) begin
			term_n = 1'b0;
			exit_n = '0;
			kind_n = KIND_NONE;
		end else if (is_wr && (size_q == SZ_WORD) && fin_hit_q) begin
			case (data_q[15:0])
				FIN_PASS: begin
					term_n = 1'b1;
					exit_n = '0;
					kind_n = KIND_PASS;
				end
				FIN_FAIL: begin
					term_n = 1'b1;
					exit_n = (data_q[31:16] == 16'h0000) ? 16'h0001 : data_q[31:16];
					kind_n = KIND_FAIL;
				end
				FIN_RESET: begin
					term_n = 1'b1;
					exit_n = (data_q[31:16] == 16'h0000) ? 16'h0001 : data_q[31:16];
					kind_n = KIND_RESET;
				end
				default: begin
					term_n = term_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= 1'b0;
			exit_q <= '0;
			kind_q <= KIND_NONE;
		end else if (cmd.finish) begin
			term_q <= term_n;
			exit_q <= exit_n;
			kind_q <= kind_n;
		end
	end

	// output register
	logic        out_valid_q;
	logic [63:0] read_data_q;
	logic        read_valid_q;
	logic        unsup_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			read_data_q  <= rd_ok ? rd_bytes : 64'h0;
			read_valid_q <= rd_ok;
			unsup_q      <= (op_q == OP_WRITE) && (size_q == SZ_HALF);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign read_valid  = read_valid_q;
	assign unsupported = unsup_q;
	assign terminated  = term_q;
	assign exit_status = exit_q;
	assign finish_kind = kind_q;

	assign stat.opcode     = op_q;
	assign stat.size_code  = size_q;
	assign stat.sweep_last = (sweep_q == LAST_ROW);
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

/* rtl/memory_with_test_finisher.sv */
// Byte-addressed memory window of MEM_BYTES bytes starting at window_base, with a
// valid mark per byte, plus a test finisher at finisher_address. The store is split
// into eight byte-lane RAM banks of ceil(MEM_BYTES/8) rows, so any 1, 2, 4 or 8 byte
// access, at any alignment, touches each bank at most once. One item is in flight
// at a time and walks accept, offset, lane decode, bank access and result; a
// two-byte write or an unused opcode goes from offset straight to result. A clear
// sweeps every bank row to drop the valid marks. After reset the same sweep runs
// with in_stall high; configuration writes are taken throughout. The result
// register frees the input side: the next beat is taken while a finished result
// still waits on out_stall. terminated, exit_status and finish_kind show the
// finisher state after the step of the result beat.
module memory_with_test_finisher import mwtf_pkg::*; #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [1:0]           size_code,
	input  logic [63:0]          address,
	input  logic [63:0]          write_data,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          read_data,
	output logic                 read_valid,
	output logic                 unsupported,
	output logic                 terminated,
	output logic [15:0]          exit_status,
	output logic [1:0]           finish_kind
);

	// command and status between sequencer and datapath
	mwtf_cmd_t  cmd;
	mwtf_stat_t stat;

	// sequencer: steps one beat through its phases and runs the clearing sweep
	mwtf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath: config registers, window offset, byte banks, finisher, result register
	mwtf_dp #(
		.MEM_BYTES(MEM_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.opcode     (opcode),
		.size_code  (size_code),
		.address    (address),
		.write_data (write_data),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.read_valid (read_valid),
		.unsupported(unsupported),
		.terminated (terminated),
		.exit_status(exit_status),
		.finish_kind(finish_kind)
	);

endmodule

/* rtl/mwtf_checker.sv */
module mwtf_checker import mwtf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [63:0]          read_data,
	input logic                 read_valid,
	input logic                 unsupported,
	input logic                 terminated,
	input logic [15:0]          exit_status,
	input logic [1:0]           finish_kind
);

	// one beat at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// finisher state stays consistent
	a_idle_finisher: assert property (@(posedge clk) disable iff (!arst_n)
		!terminated |-> (exit_status == 16'h0000) && (finish_kind == KIND_NONE))
		else $error("finisher code or kind without terminated");

	a_term_kind: assert property (@(posedge clk) disable iff (!arst_n)
		terminated |-> (finish_kind != KIND_NONE))
		else $error("terminated without finisher kind");

	// a failed read returns zero data, and a read is never also unsupported
	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (read_valid || (read_data == 64'h0)) && !(read_valid && unsupported))
		else $error("inconsistent result flags");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(read_data) && $stable(read_valid))
		else $error("stalled result beat changed");

endmodule

bind memory_with_test_finisher mwtf_checker u_mwtf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_data  (read_data),
	.read_valid (read_valid),
	.unsupported(unsupported),
	.terminated (terminated),
	.exit_status(exit_status),
	.finish_kind(finish_kind)
);
